// File: design/phmr_pkg.sv
package phmr_pkg;

  // register word indexes on the configuration port
  localparam int unsigned REG_ROUND_COUNT = 0;

  // round count after reset
  localparam logic [2:0] ROUND_COUNT_RESET = 3'd4;

  // fixed 256-entry byte permutation
  localparam logic [7:0] PERM_TABLE [256] = '{
    8'd175, 8'd235, 8'd43,  8'd181, 8'd108, 8'd210, 8'd253, 8'd28,
    8'd1,   8'd41,  8'd173, 8'd78,  8'd218, 8'd61,  8'd32,  8'd17,
    8'd31,  8'd158, 8'd147, 8'd186, 8'd206, 8'd254, 8'd239, 8'd39,
    8'd85,  8'd152, 8'd150, 8'd92,  8'd196, 8'd11,  8'd164, 8'd72,
    8'd222, 8'd8,   8'd183, 8'd129, 8'd180, 8'd234, 8'd29,  8'd121,
    8'd79,  8'd116, 8'd212, 8'd16,  8'd117, 8'd193, 8'd189, 8'd226,
    8'd199, 8'd50,  8'd9,   8'd131, 8'd14,  8'd47,  8'd80,  8'd203,
    8'd124, 8'd53,  8'd162, 8'd238, 8'd83,  8'd157, 8'd231, 8'd88,
    8'd110, 8'd109, 8'd62,  8'd245, 8'd114, 8'd105, 8'd73,  8'd242,
    8'd22,  8'd56,  8'd84,  8'd42,  8'd0,   8'd38,  8'd144, 8'd94,
    8'd249, 8'd77,  8'd137, 8'd224, 8'd74,  8'd168, 8'd75,  8'd59,
    8'd71,  8'd248, 8'd208, 8'd44,  8'd176, 8'd112, 8'd184, 8'd182,
    8'd190, 8'd246, 8'd10,  8'd192, 8'd115, 8'd146, 8'd195, 8'd160,
    8'd15,  8'd48,  8'd145, 8'd191, 8'd107, 8'd100, 8'd58,  8'd104,
    8'd217, 8'd102, 8'd76,  8'd170, 8'd149, 8'd111, 8'd148, 8'd132,
    8'd142, 8'd66,  8'd237, 8'd69,  8'd27,  8'd89,  8'd126, 8'd82,
    8'd87,  8'd227, 8'd171, 8'd232, 8'd185, 8'd49,  8'd216, 8'd135,
    8'd243, 8'd251, 8'd103, 8'd141, 8'd236, 8'd153, 8'd228, 8'd64,
    8'd93,  8'd25,  8'd21,  8'd20,  8'd127, 8'd155, 8'd98,  8'd23,
    8'd67,  8'd51,  8'd40,  8'd99,  8'd201, 8'd241, 8'd214, 8'd34,
    8'd60,  8'd18,  8'd159, 8'd45,  8'd166, 8'd55,  8'd205, 8'd86,
    8'd134, 8'd219, 8'd169, 8'd204, 8'd26,  8'd244, 8'd174, 8'd143,
    8'd198, 8'd65,  8'd140, 8'd122, 8'd161, 8'd165, 8'd223, 8'd207,
    8'd187, 8'd178, 8'd118, 8'd202, 8'd13,  8'd177, 8'd230, 8'd197,
    8'd54,  8'd194, 8'd247, 8'd119, 8'd113, 8'd136, 8'd221, 8'd133,
    8'd57,  8'd12,  8'd167, 8'd81,  8'd70,  8'd172, 8'd30,  8'd255,
    8'd5,   8'd37,  8'd213, 8'd101, 8'd215, 8'd90,  8'd6,   8'd52,
    8'd33,  8'd97,  8'd240, 8'd123, 8'd233, 8'd7,   8'd63,  8'd125,
    8'd120, 8'd2,   8'd188, 8'd128, 8'd179, 8'd96,  8'd154, 8'd95,
    8'd24,  8'd209, 8'd151, 8'd35,  8'd252, 8'd19,  8'd46,  8'd106,
    8'd163, 8'd225, 8'd138, 8'd211, 8'd130, 8'd220, 8'd156, 8'd229,
    8'd91,  8'd200, 8'd36,  8'd3,   8'd250, 8'd68,  8'd4,   8'd139
  };

endpackage

// File: design/pearson_hash_multi_round_top.sv
// Multi-round Pearson hash over a byte stream.
// Input channel in_*: one string byte per item in in_tdata, in_tlast marks
// the final item of a string, in_tuser set means the item carries no byte
// (an empty string is one item with in_tlast and in_tuser both set).
// Output channel out_*: one 32-bit hash per string, sent after its last item,
// round 0 in the most significant used byte, unused upper bytes zero.
// Config port cfg_*: register 0 at byte address 0 holds the round count.
// Throughput: one item per cycle, except while a last item is held in stage
// one, set by one table lookup per round with all rounds side by side. An
// item is registered in stage one at acceptance and processed there; the hash
// of a last item is registered in the output register as that item leaves it.
// The round state lives in a one-word memory with a registered read; the
// word written in one cycle is forwarded to the next item, and a seed flag
// stands for the reloaded seeds, so no clearing pass is needed.
// Reset loads the seeds and sets the round count to four; no sweep runs.
// When out_tready is low with a hash waiting, items without in_tlast keep
// flowing; the next last item is held in stage one and in_tready drops
// until the hash is taken.
module pearson_hash_multi_round_top
  import phmr_pkg::*;
#(
  parameter int unsigned MAX_ROUNDS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [7:0] data_byte
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  // in_tuser: [0] no_data
  input  logic        in_tuser,
  // out_tdata: [31:0] hash_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned STATE_W = MAX_ROUNDS * 8;

  // configuration register
  logic [2:0] round_count_r;
  logic       cfg_wr;
  logic       cfg_sel_rc;

  assign cfg_pready = 1'b1;
  assign cfg_sel_rc = (cfg_paddr[2] == 1'(REG_ROUND_COUNT));
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_count_r <= ROUND_COUNT_RESET;
    end else if (cfg_wr && cfg_sel_rc) begin
      round_count_r <= cfg_pwdata[2:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_sel_rc) begin
      cfg_prdata = {29'd0, round_count_r};
    end
  end

  // stage 1: accepted item
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_nodata_r;
  logic       s1_adv;
  logic       out_free;
  logic       out_valid_r;
  logic [31:0] out_data_r;
  logic [31:0] out_data_nxt;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r   <= in_tdata;
      s1_last_r   <= in_tlast;
      s1_nodata_r <= in_tuser;
    end
  end

  // round state memory, read every cycle
  logic [STATE_W-1:0] state_mem [1];
  logic [STATE_W-1:0] state_rd_r;
  logic [STATE_W-1:0] fwd_data_r;
  logic               fwd_r;
  logic               seed_r;
  logic               wr_en;
  logic [STATE_W-1:0] state_cur;
  logic [STATE_W-1:0] state_new;

  assign wr_en = s1_adv && !s1_nodata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      state_mem[0] <= state_new;
    end
    state_rd_r <= state_mem[0];
  end

  // forward the word written last cycle; seed flag overrides both
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r  <= 1'b0;
      seed_r <= 1'b1;
    end else begin
      fwd_r <= wr_en;
      if (s1_adv) begin
        if (s1_last_r) begin
          seed_r <= 1'b1;
        end else if (!s1_nodata_r) begin
          seed_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_data_r <= state_new;
    end
  end

  // current accumulators and one table step per round
  always_comb begin
    for (int r = 0; r < MAX_ROUNDS; r++) begin
      if (seed_r) begin
        state_cur[8*r +: 8] = PERM_TABLE[r];
      end else if (fwd_r) begin
        state_cur[8*r +: 8] = fwd_data_r[8*r +: 8];
      end else begin
        state_cur[8*r +: 8] = state_rd_r[8*r +: 8];
      end
    end
    for (int r = 0; r < MAX_ROUNDS; r++) begin
      if (s1_nodata_r) begin
        state_new[8*r +: 8] = state_cur[8*r +: 8];
      end else begin
        state_new[8*r +: 8] = PERM_TABLE[state_cur[8*r +: 8] ^ s1_byte_r];
      end
    end
  end

  // clamp round count and pack round bytes, round 0 highest
  logic [2:0] n_eff;

  always_comb begin
    if (round_count_r == 3'd0) begin
      n_eff = 3'd1;
    end else if (round_count_r > 3'(MAX_ROUNDS)) begin
      n_eff = 3'(MAX_ROUNDS);
    end else begin
      n_eff = round_count_r;
    end
    out_data_nxt = '0;
    for (int r = 0; r < MAX_ROUNDS; r++) begin
      if (3'(r) < n_eff) begin
        out_data_nxt = {out_data_nxt[23:0], state_new[8*r +: 8]};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a new hash only follows a processed last item
  a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(s1_adv && s1_last_r))
    else $error("hash appeared without a last item");

  // seeds reload after every last item
  a_seed_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> seed_r)
    else $error("seeds not reloaded after last item");

  // input only stalls behind a held last item and a blocked output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_tready))
    else $error("input stalled without cause");

  // forwarded word is the one written last cycle
  a_fwd_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> (fwd_data_r == $past(state_new)))
    else $error("forwarded state mismatch");

endmodule
